[hw/rtl/websocket_frame_deframer_top_macros.svh]
// Assertion macros shared by the deframer checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define WSD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising edge, off during reset.
`define WSD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/wsd_pkg.sv]
// Types and constants for the WebSocket frame deframer.
// No dependencies; used by every module of the block.
package wsd_pkg;

    // Result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Opcode of a close frame
    localparam logic [3:0] OP_CLOSE = 4'd8;

    // Length field codes and header byte counts
    localparam logic [6:0] LEN_SHORT_MAX = 7'd125;
    localparam logic [6:0] LEN_EXT16     = 7'd126;
    localparam logic [3:0] EXT16_BYTES   = 4'd2;
    localparam logic [3:0] EXT64_BYTES   = 4'd8;
    localparam logic [3:0] KEY_BYTES     = 4'd4;

    localparam int LEN_W = 63;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       frame_start;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       out_kind;
        logic [7:0]       out_byte;
        logic             fin_flag;
        logic [3:0]       op_code;
        logic [LEN_W-1:0] payload_length;
        logic             close_valid;
        logic [15:0]      close_status;
        logic             frame_last;
    } out_item_t;

endpackage

[hw/rtl/wsd_parser.sv]
// Frame header parser and payload unmasker: holds the per-frame state and
// forms one result per accepted byte. Depends on wsd_pkg.
module wsd_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  wsd_pkg::in_item_t   item,
    output wsd_pkg::out_item_t  result
);

    typedef enum logic [2:0] {
        PH_HDR1 = 3'd0,
        PH_HDR2 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_DATA = 3'd4,
        PH_DROP = 3'd5
    } phase_t;

    phase_t                    phase_reg, phase_next, phase_cur;
    logic [3:0]                count_reg, count_next;
    logic [wsd_pkg::LEN_W-1:0] length_reg, length_next;
    logic [wsd_pkg::LEN_W-1:0] remaining_reg, remaining_next;
    logic [wsd_pkg::LEN_W-1:0] shifted;
    logic [31:0]               key_reg, key_next;
    logic [1:0]                key_index_reg, key_index_next;
    logic [1:0]                data_count_reg, data_count_next;
    logic                      fin_reg, fin_next;
    logic [3:0]                opcode_reg, opcode_next;
    logic                      close_valid_reg, close_valid_next;
    logic [15:0]               close_status_reg, close_status_next;

    logic [7:0] b;
    logic [7:0] key_byte;
    logic [7:0] obyte;
    logic [1:0] kind;
    logic       last;
    logic       len_known;

    assign b       = item.in_byte;
    assign shifted = {length_reg[wsd_pkg::LEN_W-9:0], b};

    always_comb
    begin
        case (key_index_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_cur         = item.frame_start ? PH_HDR1 : phase_reg;
        phase_next        = phase_cur;
        count_next        = count_reg;
        length_next       = length_reg;
        remaining_next    = remaining_reg;
        key_next          = key_reg;
        key_index_next    = key_index_reg;
        data_count_next   = data_count_reg;
        fin_next          = fin_reg;
        opcode_next       = opcode_reg;
        close_valid_next  = close_valid_reg;
        close_status_next = close_status_reg;
        kind              = wsd_pkg::KIND_HEADER;
        obyte             = 8'd0;
        last              = 1'b0;

        unique case (phase_cur)
            PH_HDR1:
            begin
                fin_next          = b[7];
                opcode_next       = b[3:0];
                close_valid_next  = 1'b0;
                close_status_next = 16'd0;
                length_next       = '0;
                remaining_next    = '0;
                key_next          = 32'd0;
                key_index_next    = 2'd0;
                data_count_next   = 2'd0;
                count_next        = 4'd0;
                phase_next        = PH_HDR2;
            end
            PH_HDR2:
            begin
                if (!b[7])
                begin
                    kind       = wsd_pkg::KIND_ERROR;
                    last       = 1'b1;
                    phase_next = PH_DROP;
                end
                else if (b[6:0] <= wsd_pkg::LEN_SHORT_MAX)
                begin
                    length_next    = {{(wsd_pkg::LEN_W-7){1'b0}}, b[6:0]};
                    remaining_next = {{(wsd_pkg::LEN_W-7){1'b0}}, b[6:0]};
                    count_next     = wsd_pkg::KEY_BYTES;
                    phase_next     = PH_KEY;
                end
                else
                begin
                    length_next = '0;
                    count_next  = (b[6:0] == wsd_pkg::LEN_EXT16) ? wsd_pkg::EXT16_BYTES
                                                                  : wsd_pkg::EXT64_BYTES;
                    phase_next  = PH_EXT;
                end
            end
            PH_EXT:
            begin
                // Network byte order: shift the running length up one byte
                length_next = shifted;
                count_next  = count_reg - 4'd1;
                if (count_reg == 4'd1)
                begin
                    remaining_next = shifted;
                    count_next     = wsd_pkg::KEY_BYTES;
                    phase_next     = PH_KEY;
                end
            end
            PH_KEY:
            begin
                key_next   = {key_reg[23:0], b};
                count_next = count_reg - 4'd1;
                if (count_reg == 4'd1)
                begin
                    key_index_next = 2'd0;
                    if (remaining_reg == '0)
                    begin
                        last       = 1'b1;
                        phase_next = PH_HDR1;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                obyte = b ^ key_byte;
                kind  = wsd_pkg::KIND_DATA;
                if (opcode_reg == wsd_pkg::OP_CLOSE)
                begin
                    if (data_count_reg == 2'd0)
                    begin
                        close_status_next = {obyte, 8'd0};
                        close_valid_next  = 1'b0;
                    end
                    else if (data_count_reg == 2'd1)
                    begin
                        close_status_next = {close_status_reg[15:8], obyte};
                        close_valid_next  = 1'b1;
                    end
                end
                // Count the first two payload bytes only
                if (data_count_reg != 2'd2)
                begin
                    data_count_next = data_count_reg + 2'd1;
                end
                key_index_next = key_index_reg + 2'd1;
                remaining_next = remaining_reg - {{(wsd_pkg::LEN_W-1){1'b0}}, 1'b1};
                if (remaining_reg == {{(wsd_pkg::LEN_W-1){1'b0}}, 1'b1})
                begin
                    last       = 1'b1;
                    phase_next = PH_HDR1;
                end
            end
            default:
            begin
                kind       = wsd_pkg::KIND_ERROR;
                phase_next = PH_DROP;
            end
        endcase

        len_known = (phase_next == PH_KEY) || (phase_next == PH_DATA) ||
                    ((phase_next == PH_HDR1) && (kind != wsd_pkg::KIND_ERROR));

        result.out_kind       = kind;
        result.out_byte       = obyte;
        result.fin_flag       = fin_next;
        result.op_code        = opcode_next;
        result.payload_length = len_known ? length_next : '0;
        result.close_valid    = close_valid_next;
        result.close_status   = close_valid_next ? close_status_next : 16'd0;
        result.frame_last     = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HDR1;
            count_reg        <= 4'd0;
            length_reg       <= '0;
            remaining_reg    <= '0;
            key_reg          <= 32'd0;
            key_index_reg    <= 2'd0;
            data_count_reg   <= 2'd0;
            fin_reg          <= 1'b0;
            opcode_reg       <= 4'd0;
            close_valid_reg  <= 1'b0;
            close_status_reg <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            count_reg        <= count_next;
            length_reg       <= length_next;
            remaining_reg    <= remaining_next;
            key_reg          <= key_next;
            key_index_reg    <= key_index_next;
            data_count_reg   <= data_count_next;
            fin_reg          <= fin_next;
            opcode_reg       <= opcode_next;
            close_valid_reg  <= close_valid_next;
            close_status_reg <= close_status_next;
        end
    end

endmodule

[hw/rtl/websocket_frame_deframer_top.sv]
// WebSocket client-to-server frame deframer, top level.
// Depends on wsd_pkg and wsd_parser.
//
// Usage:
//   Byte channel (byte_valid / byte_stall / byte_item): one raw byte of the
//   frame stream per item, with frame_start to force a header resync.
//   Result channel (result_valid / result_stall / result_item): exactly one
//   result item per byte item, in order: header consumed, unmasked payload
//   byte or error, with the frame fields and close code alongside.
//   Each result is registered, in the result register or, if the receiver
//   stalls, the skid entry. Throughput: one byte per clock while byte_stall
//   is low, set by the parser state (header phase, length, key, remaining).
//   Stall: the result register is backed by one skid entry, so a byte is
//   still taken in the cycle the receiver first stalls; byte_stall rises
//   only once both hold an item and falls as soon as the skid drains.
//   Reset: asynchronous, active low. Clears both result slots and returns
//   the parser to expect a first header byte; no clearing pass is needed.
//   byte_stall is a register output and never depends on byte_valid.
module websocket_frame_deframer_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  wsd_pkg::in_item_t   byte_item,
    output logic                result_valid,
    input  logic                result_stall,
    output wsd_pkg::out_item_t  result_item
);

    wsd_pkg::out_item_t parsed;
    wsd_pkg::out_item_t result_item_reg;
    wsd_pkg::out_item_t skid_item_reg;
    logic               result_valid_reg;
    logic               skid_valid_reg;
    logic               accept;
    logic               take;

    // Take a byte whenever the skid entry is free
    assign accept = byte_valid && !skid_valid_reg;
    assign take   = result_valid_reg && !result_stall;

    wsd_parser u_parser
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (byte_item),
        .result (parsed)
    );

    // Occupancy of the result register and skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (!result_valid_reg || take)
            begin
                result_valid_reg <= 1'b1;
            end
            else
            begin
                // Receiver held the result: park the new item
                skid_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the two slots; follows the occupancy decisions above
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!result_valid_reg || take)
            begin
                result_item_reg <= parsed;
            end
            else
            begin
                skid_item_reg <= parsed;
            end
        end
        else if (take && skid_valid_reg)
        begin
            // Advance the parked item into the result register
            result_item_reg <= skid_item_reg;
        end
    end

    assign byte_stall   = skid_valid_reg;
    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

endmodule

[hw/rtl/wsd_checker.sv]
// Port-level checks for the deframer, bound to the top level.
// Depends on wsd_pkg and websocket_frame_deframer_top_macros.svh.
`include "websocket_frame_deframer_top_macros.svh"

module wsd_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               byte_stall,
    input logic               result_valid,
    input logic               result_stall,
    input wsd_pkg::out_item_t result_item
);

    // A held result stays put until taken
    `WSD_ASSERT_NXT(a_hold, result_valid && result_stall,
        result_valid && $stable(result_item), "result changed while stalled")

    // Input stalls only when both result slots are full
    `WSD_ASSERT_IMP(a_stall_full, byte_stall, result_valid, "byte stall with no result pending")

    // A close code only belongs to a close frame
    `WSD_ASSERT_IMP(a_close_op, result_valid && result_item.close_valid,
        result_item.op_code == wsd_pkg::OP_CLOSE, "close code on a non-close frame")

    // Data byte is zero unless the result carries payload
    `WSD_ASSERT_IMP(a_byte_zero, result_valid && (result_item.out_kind != wsd_pkg::KIND_DATA),
        result_item.out_byte == 8'd0, "data byte on a non-payload result")

    // Close code reads zero until both bytes are in
    `WSD_ASSERT_IMP(a_code_zero, result_valid && !result_item.close_valid,
        result_item.close_status == 16'd0, "close code shown while not valid")

endmodule

bind websocket_frame_deframer_top wsd_checker u_wsd_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_stall   (byte_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
);
